>>> rtl/pct_pkg.sv
`default_nettype none

package pct_pkg;

    localparam int FREQ_W  = 24;
    localparam int STR_W   = 16;
    localparam int CNT_W   = 5;
    localparam int ENTRY_W = FREQ_W + STR_W;

    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // register index, taken from paddr[2]
    localparam logic REG_MAX_CANDIDATES = 1'b0;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    localparam logic signed [STR_W-1:0] STRENGTH_NONE = -16'sd16384;
    localparam logic [CNT_W-1:0]        MAX_CAND_RESET = 5'd16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WSCAN,
        S_WRITE,
        S_BSCAN,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

>>> rtl/pct_if.sv
`default_nettype none

interface pct_item_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  func;
    logic        [pct_pkg::FREQ_W-1:0]     cand_frequency;
    logic signed [pct_pkg::STR_W-1:0]      cand_strength;

    modport source (output valid, output func, output cand_frequency,
                    output cand_strength, input ready);
    modport sink   (input valid, input func, input cand_frequency,
                    input cand_strength, output ready);
endinterface

interface pct_res_if;
    logic                                  valid;
    logic                                  ready;
    logic        [pct_pkg::FREQ_W-1:0]     best_frequency;
    logic signed [pct_pkg::STR_W-1:0]      best_strength;
    logic        [pct_pkg::CNT_W-1:0]      entry_count;
    logic                                  was_stored;

    modport source (output valid, output best_frequency, output best_strength,
                    output entry_count, output was_stored, input ready);
    modport sink   (input valid, input best_frequency, input best_strength,
                    input entry_count, input was_stored, output ready);
endinterface

`default_nettype wire

>>> rtl/pitch_candidate_table_top.sv
// Pitch candidate table for one analysis frame.
// i_item carries one transaction per candidate: func add or clear, frequency
// (Q16.8 Hz, zero = unvoiced) and strength (Q2.14). o_res returns exactly one
// transaction per item: strongest voiced entry, entry count and a stored flag.
// max_candidates is set over the APB port (register 0, reset 16); the user
// must write it only while idle; the block leaves enforcing this to the user.
// Table entries live in one synchronous RAM (one read or write per cycle);
// the scans walk through that RAM one entry after another.
// A clear empties the table and returns its result without a scan. An add
// to a table holding fewer than min(max_candidates, MAX_ENTRIES) entries
// writes the item at the next free position, then scans for the strongest
// voiced entry; at that limit it first scans for the weakest voiced entry,
// replaces it if the item is at least as strong, then scans for the strongest.
// The next item can be accepted in the cycle after the result is loaded.
// A result that is not taken waits in the output register; the next item is
// accepted meanwhile, and its result waits until the register frees up.
// Reset empties the table (count zero) and drops any result in flight;
// the RAM itself is not cleared.
`default_nettype none

module pitch_candidate_table_top #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    pct_item_if.sink                          i_item,
    pct_res_if.source                         o_res,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [pct_pkg::APB_AW-1:0]   paddr,
    input  wire logic [pct_pkg::APB_DW-1:0]   pwdata,
    output logic      [pct_pkg::APB_DW-1:0]   prdata,
    output logic                              pready
);

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int FW = pct_pkg::FREQ_W;
    localparam int SW = pct_pkg::STR_W;
    localparam int EW = pct_pkg::ENTRY_W;
    localparam int NW = pct_pkg::CNT_W;

    pct_pkg::t_state r_state, n_state;

    logic [EW-1:0] r_mem [MAX_ENTRIES];
    logic [EW-1:0] r_rdata;
    logic [IW-1:0] w_rd_addr;

    logic        [FW-1:0] r_f, n_f;
    logic signed [SW-1:0] r_s, n_s;
    logic        [CW-1:0] r_idx, n_idx;
    logic        [CW-1:0] r_end, n_end;
    logic        [CW-1:0] r_pidx, n_pidx;
    logic                 r_pend, n_pend;
    logic                 r_wfound, n_wfound;
    logic signed [SW-1:0] r_weak, n_weak;
    logic        [IW-1:0] r_pos, n_pos;
    logic signed [SW-1:0] r_best, n_best;
    logic        [FW-1:0] r_best_f, n_best_f;
    logic                 r_stored, n_stored;
    logic        [CW-1:0] r_held, n_held;
    logic        [NW-1:0] r_maxc;

    logic                 r_ovalid, n_ovalid;
    logic        [FW-1:0] r_obest_f, n_obest_f;
    logic signed [SW-1:0] r_obest, n_obest;
    logic        [NW-1:0] r_ocount, n_ocount;
    logic                 r_ostored, n_ostored;

    logic        [CW-1:0] w_lim;
    logic                 w_accept;
    logic                 w_scan_done;
    logic                 w_out_free;
    logic                 w_replace;
    logic        [FW-1:0] w_rd_f;
    logic signed [SW-1:0] w_rd_s;
    logic                 w_rd_voiced;
    logic                 w_cfg_wr;

    assign w_lim = (32'(r_maxc) > MAX_ENTRIES) ? CW'(MAX_ENTRIES) : CW'(r_maxc);

    assign i_item.ready = (r_state == pct_pkg::S_IDLE);
    assign w_accept     = i_item.valid && i_item.ready;
    assign w_scan_done  = (r_idx >= r_end) && !r_pend;
    assign w_out_free   = !r_ovalid || o_res.ready;
    assign w_replace    = r_wfound && (r_s >= r_weak);

    assign w_rd_addr   = IW'(r_idx);
    assign w_rd_f      = r_rdata[EW-1:SW];
    assign w_rd_s      = r_rdata[SW-1:0];
    assign w_rd_voiced = (w_rd_f != '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pct_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_item.func == pct_pkg::FUNC_CLEAR) begin
                        n_state = pct_pkg::S_OUT;
                    end else if (r_held < w_lim) begin
                        n_state = pct_pkg::S_WRITE;
                    end else begin
                        n_state = pct_pkg::S_WSCAN;
                    end
                end
            end
            pct_pkg::S_WSCAN: begin
                if (w_scan_done) begin
                    n_state = w_replace ? pct_pkg::S_WRITE : pct_pkg::S_BSCAN;
                end
            end
            pct_pkg::S_WRITE: n_state = pct_pkg::S_BSCAN;
            pct_pkg::S_BSCAN: begin
                if (w_scan_done) begin
                    n_state = pct_pkg::S_OUT;
                end
            end
            pct_pkg::S_OUT: begin
                if (w_out_free) begin
                    n_state = pct_pkg::S_IDLE;
                end
            end
            default: n_state = pct_pkg::S_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_f       = r_f;
        n_s       = r_s;
        n_idx     = r_idx;
        n_end     = r_end;
        n_pidx    = r_pidx;
        n_pend    = r_pend;
        n_wfound  = r_wfound;
        n_weak    = r_weak;
        n_pos     = r_pos;
        n_best    = r_best;
        n_best_f  = r_best_f;
        n_stored  = r_stored;
        n_held    = r_held;
        n_ovalid  = r_ovalid;
        n_obest_f = r_obest_f;
        n_obest   = r_obest;
        n_ocount  = r_ocount;
        n_ostored = r_ostored;

        if (r_ovalid && o_res.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            pct_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_f      = i_item.cand_frequency;
                    n_s      = i_item.cand_strength;
                    n_best   = pct_pkg::STRENGTH_NONE;
                    n_best_f = '0;
                    n_stored = 1'b0;
                    n_wfound = 1'b0;
                    n_idx    = '0;
                    n_pend   = 1'b0;
                    if (i_item.func == pct_pkg::FUNC_CLEAR) begin
                        n_held = '0;
                    end else if (r_held < w_lim) begin
                        n_pos  = IW'(r_held);
                        n_held = r_held + 1'b1;
                    end else begin
                        n_end = w_lim;
                    end
                end
            end
            pct_pkg::S_WSCAN, pct_pkg::S_BSCAN: begin
                // one read issued per cycle, data processed in the next cycle
                if (r_idx < r_end) begin
                    n_idx  = r_idx + 1'b1;
                    n_pend = 1'b1;
                    n_pidx = r_idx;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    if (r_state == pct_pkg::S_WSCAN) begin
                        if (w_rd_voiced && (!r_wfound || (w_rd_s < r_weak))) begin
                            n_wfound = 1'b1;
                            n_weak   = w_rd_s;
                            n_pos    = IW'(r_pidx);
                        end
                    end else begin
                        // entry one is the fallback when nothing qualifies
                        if (r_pidx == '0) begin
                            n_best_f = w_rd_f;
                        end
                        if (w_rd_voiced && (w_rd_s > r_best)) begin
                            n_best   = w_rd_s;
                            n_best_f = w_rd_f;
                        end
                    end
                end
                if (w_scan_done && (r_state == pct_pkg::S_WSCAN)) begin
                    n_idx = '0;
                    n_end = r_held;
                end
            end
            pct_pkg::S_WRITE: begin
                n_stored = 1'b1;
                n_idx    = '0;
                n_end    = r_held;
                n_pend   = 1'b0;
            end
            pct_pkg::S_OUT: begin
                if (w_out_free) begin
                    n_ovalid  = 1'b1;
                    n_obest_f = r_best_f;
                    n_obest   = r_best;
                    n_ocount  = NW'(r_held);
                    n_ostored = r_stored;
                end
            end
            default: begin
            end
        endcase
    end

    // table RAM
    always_ff @(posedge i_clk) begin
        if (r_state == pct_pkg::S_WRITE) begin
            r_mem[r_pos] <= {r_f, r_s};
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pct_pkg::S_IDLE;
            r_held   <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_held   <= n_held;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f       <= n_f;
        r_s       <= n_s;
        r_idx     <= n_idx;
        r_end     <= n_end;
        r_pidx    <= n_pidx;
        r_wfound  <= n_wfound;
        r_weak    <= n_weak;
        r_pos     <= n_pos;
        r_best    <= n_best;
        r_best_f  <= n_best_f;
        r_stored  <= n_stored;
        r_obest_f <= n_obest_f;
        r_obest   <= n_obest;
        r_ocount  <= n_ocount;
        r_ostored <= n_ostored;
    end

    assign o_res.valid          = r_ovalid;
    assign o_res.best_frequency = r_obest_f;
    assign o_res.best_strength  = r_obest;
    assign o_res.entry_count    = r_ocount;
    assign o_res.was_stored     = r_ostored;

    // APB register
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (paddr[2] == pct_pkg::REG_MAX_CANDIDATES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_maxc <= pct_pkg::MAX_CAND_RESET;
        end else if (w_cfg_wr) begin
            r_maxc <= pwdata[NW-1:0];
        end
    end

    assign prdata = (paddr[2] == pct_pkg::REG_MAX_CANDIDATES)
                    ? {{(pct_pkg::APB_DW-NW){1'b0}}, r_maxc} : '0;

    // checks
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_held) <= MAX_ENTRIES)
        else $error("held count above table depth");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_item.func == pct_pkg::FUNC_CLEAR)) |=> (r_held == '0))
        else $error("clear did not empty the table");

    a_stored_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.was_stored) |-> (o_res.entry_count != '0))
        else $error("stored item reported with empty table");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_pidx < r_end))
        else $error("scan read beyond its end");

endmodule

`default_nettype wire
